FILE: design/mono_note_priority_gate_unit_assert.svh
// Assertion macros for the mono note priority gate unit.
`ifndef MONO_NOTE_PRIORITY_GATE_UNIT_ASSERT_SVH
`define MONO_NOTE_PRIORITY_GATE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MNPG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MNPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mnpg_pkg.sv
// Shared types and constants for the mono note priority gate unit.
`default_nettype none

package mnpg_pkg;

    localparam int NOTE_DEPTH_DEF       = 16;
    localparam int GATE_QUEUE_DEPTH_DEF = 8;

    localparam logic [2:0] OP_NOTE_ON    = 3'd0;
    localparam logic [2:0] OP_NOTE_OFF   = 3'd1;
    localparam logic [2:0] OP_ALL_OFF    = 3'd2;
    localparam logic [2:0] OP_PEDAL      = 3'd3;
    localparam logic [2:0] OP_POP_EVENT  = 3'd4;
    localparam logic [2:0] OP_CLEAR_FLAG = 3'd5;
    localparam logic [2:0] OP_SOFT_RESET = 3'd6;

    localparam logic [15:0]       VEL_ONE = 16'h8000;
    localparam logic signed [7:0] NO_NOTE = -8'sd1;

    typedef struct packed {
        logic       push;
        logic       remove;
        logic       clear;
        logic [6:0] key;
    } stack_ctl_t;

    typedef struct packed {
        logic push;
        logic rise;
        logic pop;
        logic clear;
    } fifo_ctl_t;

endpackage

`default_nettype wire

FILE: design/mnpg_cmd_if.sv
// Command channel: one note event per transfer.
`default_nettype none

interface mnpg_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [6:0]  note;
    logic [15:0] note_velocity;
    logic        pedal_down;

    modport source (output valid, op, note, note_velocity, pedal_down, input ready);
    modport sink   (input valid, op, note, note_velocity, pedal_down, output ready);
endinterface

`default_nettype wire

FILE: design/mnpg_res_if.sv
// Result channel: voice state after each command.
`default_nettype none

interface mnpg_res_if;
    logic              valid;
    logic              ready;
    logic              gate_on;
    logic signed [7:0] sounding_note;
    logic              legato_flag;
    logic              trigger_flag;
    logic              changed_flag;
    logic [15:0]       level;
    logic              event_valid;
    logic              event_rise;
    logic [4:0]        held_count;
    logic [3:0]        queued_events;

    modport source (output valid, gate_on, sounding_note, legato_flag, trigger_flag,
                    changed_flag, level, event_valid, event_rise, held_count,
                    queued_events, input ready);
    modport sink   (input valid, gate_on, sounding_note, legato_flag, trigger_flag,
                    changed_flag, level, event_valid, event_rise, held_count,
                    queued_events, output ready);
endinterface

`default_nettype wire

FILE: design/mnpg_note_cell.sv
// One note slot of a stack: shifts toward the bottom on push, closes gaps on removal.
`default_nettype none

module mnpg_note_cell
    import mnpg_pkg::*;
(
    input  wire logic       clk,
    input  wire stack_ctl_t ctl,
    input  wire logic [6:0] prev_note,
    input  wire logic [6:0] next_note,
    input  wire logic       valid,
    input  wire logic       hit_in,
    output logic [6:0]      note,
    output logic            hit_out
);

    logic [6:0] note_reg;
    logic [6:0] note_next;

    // A match here or in any newer slot pulls the older neighbor up.
    assign hit_out = hit_in | (valid & (note_reg == ctl.key));

    always_comb
    begin
        note_next = note_reg;
        if (ctl.push)
        begin
            note_next = prev_note;
        end
        else if (ctl.remove && hit_out)
        begin
            note_next = next_note;
        end
    end

    always_ff @(posedge clk)
    begin
        note_reg <= note_next;
    end

    assign note = note_reg;

endmodule

`default_nettype wire

FILE: design/mnpg_note_stack.sv
// Note stack built as a row of cells, newest note in cell zero.
`default_nettype none

module mnpg_note_stack
    import mnpg_pkg::*;
#(
    parameter int DEPTH = NOTE_DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire stack_ctl_t ctl,
    output logic [6:0]      top,
    output logic [CW-1:0]   count,
    output logic            found
);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [6:0]    cell_note [DEPTH];
    logic [DEPTH:0] hit;
    logic          full;

    assign hit[0] = 1'b0;
    assign full   = (count_reg == CW'(DEPTH));

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        logic [6:0] prev_n;
        logic [6:0] next_n;

        if (i == 0)
        begin : g_first
            assign prev_n = ctl.key;
        end
        else
        begin : g_mid
            assign prev_n = cell_note[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign next_n = cell_note[i];
        end
        else
        begin : g_inner
            assign next_n = cell_note[i+1];
        end

        mnpg_note_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .prev_note (prev_n),
            .next_note (next_n),
            .valid     (IDX < count_reg),
            .hit_in    (hit[i]),
            .note      (cell_note[i]),
            .hit_out   (hit[i+1])
        );
    end

    assign found = hit[DEPTH];

    // A push onto a full stack shifts the oldest note out of the last cell.
    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.push)
        begin
            count_next = full ? count_reg : count_reg + CW'(1);
        end
        else if (ctl.remove && found)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign top   = cell_note[0];
    assign count = count_reg;

endmodule

`default_nettype wire

FILE: design/mnpg_gate_fifo.sv
// Gate transition queue as a shift row, oldest entry in slot zero.
`default_nettype none

module mnpg_gate_fifo
    import mnpg_pkg::*;
#(
    parameter int DEPTH = GATE_QUEUE_DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire fifo_ctl_t ctl,
    output logic           head,
    output logic [CW-1:0]  count
);

    logic [DEPTH-1:0] slot_reg;
    logic [DEPTH-1:0] slot_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             full;
    logic             shift;

    assign full  = (count_reg == CW'(DEPTH));
    // Drop the oldest entry when a transition arrives on a full queue.
    assign shift = ctl.pop | (ctl.push & full);

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_slot
        logic upper;
        logic wr;

        if (i == DEPTH - 1)
        begin : g_last
            assign upper = slot_reg[i];
        end
        else
        begin : g_inner
            assign upper = slot_reg[i+1];
        end

        assign wr = ctl.push & (full ? (i == DEPTH - 1) : (count_reg == CW'(i)));

        always_comb
        begin
            slot_next[i] = slot_reg[i];
            if (wr)
            begin
                slot_next[i] = ctl.rise;
            end
            else if (shift)
            begin
                slot_next[i] = upper;
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (ctl.clear)
        begin
            count_next = '0;
        end
        else if (ctl.push && !full)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (ctl.pop && (count_reg != '0))
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign head  = slot_reg[0];
    assign count = count_reg;

endmodule

`default_nettype wire

FILE: design/mono_note_priority_gate_unit.sv
// Top level of the monophonic last-note-priority voice assigner.
//
// Usage: commands arrive on the cmd channel (op, note, note_velocity,
// pedal_down) and each produces exactly one result on the res channel,
// a transfer taking place when valid and ready are both high.
// Sequence: a command runs through an execute state and then a done state,
// with a follow state between them for a note-off that finds its note and
// for a pedal release, which settles the gate onto the new stack top; the
// done state loads the result into the output register. The command
// sequencer handles one command at a time and takes no new one until then.
// cmd.ready is high whenever no command is in progress, even while a
// result still waits in the output register.
// Receiver stall: a finished command waits until the output register is
// free, and no new command is taken meanwhile.
// Reset: counts, gate, flags and event queue clear, no note sounds and the
// level returns to 1.0; the soft reset command does the same.
`default_nettype none

`include "mono_note_priority_gate_unit_assert.svh"

module mono_note_priority_gate_unit
    import mnpg_pkg::*;
#(
    parameter int NOTE_DEPTH       = NOTE_DEPTH_DEF,
    parameter int GATE_QUEUE_DEPTH = GATE_QUEUE_DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mnpg_cmd_if.sink   cmd,
    mnpg_res_if.source res
);

    localparam int SCW = $clog2(NOTE_DEPTH + 1);
    localparam int QCW = $clog2(GATE_QUEUE_DEPTH + 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_EXEC   = 2'd1;
    localparam logic [1:0] S_FOLLOW = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [2:0]  op_reg;
    logic [6:0]  note_reg;
    logic [15:0] vel_reg;
    logic        pd_reg;

    logic              pedal_down_reg, pedal_down_next;
    logic              gate_reg, gate_next;
    logic signed [7:0] pitch_reg, pitch_next;
    logic              legato_reg, legato_next;
    logic              trigger_reg, trigger_next;
    logic              changed_reg, changed_next;
    logic [15:0]       level_reg, level_next;
    logic              ev_valid_reg, ev_valid_next;
    logic              ev_rise_reg, ev_rise_next;

    logic              out_valid_reg, out_valid_next;
    logic              out_load;
    logic              out_gate_reg;
    logic signed [7:0] out_note_reg;
    logic              out_legato_reg;
    logic              out_trigger_reg;
    logic              out_changed_reg;
    logic [15:0]       out_level_reg;
    logic              out_ev_valid_reg;
    logic              out_ev_rise_reg;
    logic [4:0]        out_held_reg;
    logic [3:0]        out_queued_reg;

    stack_ctl_t     held_ctl;
    stack_ctl_t     pedal_ctl;
    fifo_ctl_t      fifo_ctl;
    logic [6:0]     held_top;
    logic [SCW-1:0] held_cnt;
    logic           held_found;
    logic [6:0]     pedal_top;
    logic [SCW-1:0] pedal_cnt;
    logic           pedal_found;
    logic           fifo_head;
    logic [QCW-1:0] fifo_cnt;
    logic           cmd_xfer;

    mnpg_note_stack #(.DEPTH(NOTE_DEPTH)) u_held (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (held_ctl),
        .top   (held_top),
        .count (held_cnt),
        .found (held_found)
    );

    mnpg_note_stack #(.DEPTH(NOTE_DEPTH)) u_pedal (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (pedal_ctl),
        .top   (pedal_top),
        .count (pedal_cnt),
        .found (pedal_found)
    );

    mnpg_gate_fifo #(.DEPTH(GATE_QUEUE_DEPTH)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fifo_ctl),
        .head  (fifo_head),
        .count (fifo_cnt)
    );

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_xfer  = cmd.valid & cmd.ready;

    always_comb
    begin
        state_next      = state_reg;
        pedal_down_next = pedal_down_reg;
        gate_next       = gate_reg;
        pitch_next      = pitch_reg;
        legato_next     = legato_reg;
        trigger_next    = trigger_reg;
        changed_next    = changed_reg;
        level_next      = level_reg;
        ev_valid_next   = ev_valid_reg;
        ev_rise_next    = ev_rise_reg;
        out_load        = 1'b0;
        held_ctl        = '{push: 1'b0, remove: 1'b0, clear: 1'b0, key: note_reg};
        pedal_ctl       = '{push: 1'b0, remove: 1'b0, clear: 1'b0, key: note_reg};
        fifo_ctl        = '{push: 1'b0, rise: 1'b0, pop: 1'b0, clear: 1'b0};

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_xfer)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next    = S_DONE;
                ev_valid_next = 1'b0;
                ev_rise_next  = 1'b0;
                case (op_reg)
                    OP_NOTE_ON:
                    begin
                        held_ctl.push = 1'b1;
                        level_next    = (vel_reg > VEL_ONE) ? VEL_ONE : vel_reg;
                        trigger_next  = 1'b1;
                        legato_next   = gate_reg;
                        changed_next  = (pitch_reg != $signed({1'b0, note_reg}));
                        gate_next     = 1'b1;
                        pitch_next    = $signed({1'b0, note_reg});
                    end
                    OP_NOTE_OFF:
                    begin
                        held_ctl.remove = 1'b1;
                        if (held_found)
                        begin
                            // Keep the released note under the pedal unless that stack is full.
                            pedal_ctl.push = pedal_down_reg & (pedal_cnt != SCW'(NOTE_DEPTH));
                            state_next     = S_FOLLOW;
                        end
                    end
                    OP_ALL_OFF:
                    begin
                        held_ctl.clear  = 1'b1;
                        pedal_ctl.clear = 1'b1;
                        gate_next       = 1'b0;
                        pitch_next      = NO_NOTE;
                        legato_next     = 1'b0;
                        trigger_next    = 1'b0;
                        changed_next    = 1'b1;
                    end
                    OP_PEDAL:
                    begin
                        if (pd_reg != pedal_down_reg)
                        begin
                            pedal_down_next = pd_reg;
                            if (!pd_reg)
                            begin
                                pedal_ctl.clear = 1'b1;
                                state_next      = S_FOLLOW;
                            end
                        end
                    end
                    OP_POP_EVENT:
                    begin
                        if (fifo_cnt != '0)
                        begin
                            ev_valid_next = 1'b1;
                            ev_rise_next  = fifo_head;
                            fifo_ctl.pop  = 1'b1;
                        end
                    end
                    OP_CLEAR_FLAG:
                    begin
                        legato_next  = 1'b0;
                        trigger_next = 1'b0;
                        changed_next = 1'b0;
                    end
                    OP_SOFT_RESET:
                    begin
                        held_ctl.clear  = 1'b1;
                        pedal_ctl.clear = 1'b1;
                        fifo_ctl.clear  = 1'b1;
                        pedal_down_next = 1'b0;
                        gate_next       = 1'b0;
                        pitch_next      = NO_NOTE;
                        legato_next     = 1'b0;
                        trigger_next    = 1'b0;
                        changed_next    = 1'b0;
                        level_next      = VEL_ONE;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FOLLOW:
            begin
                state_next = S_DONE;
                // Settle gate and pitch onto the top of the updated stacks.
                if (held_cnt == '0)
                begin
                    if (pedal_down_reg && (pedal_cnt != '0))
                    begin
                        pitch_next = $signed({1'b0, pedal_top});
                        gate_next  = 1'b1;
                    end
                    else
                    begin
                        gate_next    = 1'b0;
                        pitch_next   = NO_NOTE;
                        changed_next = 1'b1;
                    end
                end
                else
                begin
                    if (pitch_reg != $signed({1'b0, held_top}))
                    begin
                        changed_next = 1'b1;
                    end
                    pitch_next = $signed({1'b0, held_top});
                    gate_next  = 1'b1;
                end
                if (op_reg == OP_PEDAL)
                begin
                    changed_next = 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Queue every change of the gate level; soft reset empties the queue instead.
        if ((gate_next != gate_reg) && !fifo_ctl.clear)
        begin
            fifo_ctl.push = 1'b1;
            fifo_ctl.rise = gate_next;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pedal_down_reg <= 1'b0;
            gate_reg       <= 1'b0;
            pitch_reg      <= NO_NOTE;
            legato_reg     <= 1'b0;
            trigger_reg    <= 1'b0;
            changed_reg    <= 1'b0;
            level_reg      <= VEL_ONE;
            ev_valid_reg   <= 1'b0;
            ev_rise_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pedal_down_reg <= pedal_down_next;
            gate_reg       <= gate_next;
            pitch_reg      <= pitch_next;
            legato_reg     <= legato_next;
            trigger_reg    <= trigger_next;
            changed_reg    <= changed_next;
            level_reg      <= level_next;
            ev_valid_reg   <= ev_valid_next;
            ev_rise_reg    <= ev_rise_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            op_reg   <= cmd.op;
            note_reg <= cmd.note;
            vel_reg  <= cmd.note_velocity;
            pd_reg   <= cmd.pedal_down;
        end
        if (out_load)
        begin
            out_gate_reg     <= gate_reg;
            out_note_reg     <= pitch_reg;
            out_legato_reg   <= legato_reg;
            out_trigger_reg  <= trigger_reg;
            out_changed_reg  <= changed_reg;
            out_level_reg    <= level_reg;
            out_ev_valid_reg <= ev_valid_reg;
            out_ev_rise_reg  <= ev_rise_reg;
            out_held_reg     <= 5'(held_cnt);
            out_queued_reg   <= 4'(fifo_cnt);
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.gate_on       = out_gate_reg;
    assign res.sounding_note = out_note_reg;
    assign res.legato_flag   = out_legato_reg;
    assign res.trigger_flag  = out_trigger_reg;
    assign res.changed_flag  = out_changed_reg;
    assign res.level         = out_level_reg;
    assign res.event_valid   = out_ev_valid_reg;
    assign res.event_rise    = out_ev_rise_reg;
    assign res.held_count    = out_held_reg;
    assign res.queued_events = out_queued_reg;

    `MNPG_ASSERT_NEXT(a_xfer_starts_exec, cmd_xfer, state_reg == S_EXEC,
        "command transfer did not start execution")
    `MNPG_ASSERT_NOW(a_gate_has_note,
        (state_reg == S_IDLE) && gate_reg && !pedal_found,
        (held_cnt != '0) || (pedal_down_reg && (pedal_cnt != '0)),
        "gate high with no held or sustained note")
    `MNPG_ASSERT_NOW(a_counts_bounded, 1'b1,
        (held_cnt <= SCW'(NOTE_DEPTH)) && (fifo_cnt <= QCW'(GATE_QUEUE_DEPTH)),
        "stack or queue count beyond depth")
    `MNPG_ASSERT_NEXT(a_load_shows_result, out_load, res.valid,
        "loaded result not presented")

endmodule

`default_nettype wire
